// ----- rtl/core/sha1_pkg.sv -----
// Types, constants and round functions shared by the SHA-1 hash core.
`default_nettype none

package sha1_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    typedef enum logic [2:0] {
        PAD_NONE,
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN,
        PAD_DONE
    } t_pad;

    localparam int unsigned NUM_CHAIN = 5;
    localparam int unsigned NUM_ROUNDS = 80;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam logic [31:0] H_INIT [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20) begin
            k = K_0;
        end else if (t < 7'd40) begin
            k = K_1;
        end else if (t < 7'd60) begin
            k = K_2;
        end else begin
            k = K_3;
        end
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            f = b ^ c ^ d;
        end else if (t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sha1_hash_core.sv -----
// SHA-1 hash core: byte packing, padding, 80-round compression and digest output.
//
// Message bytes are taken one per word in idle; a byte that completes a 64-byte
// block starts a compression (reading the chain memory into A..E, 80 rounds at
// one round per cycle through the single round adder, then read-add-write back
// into the chain memory). An end word appends padding one byte per cycle while no
// compression runs, followed by one or two more compressions; then the five
// digest words come out one at a time, each read from the chain memory into the
// output register once that register is free or being taken. The block takes a
// new word while the last digest word still waits in the output register.
`default_nettype none

module sha1_hash_core
    import sha1_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_message,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_number,
    output logic             o_final_word
);

    // control state
    t_state      r_state, n_state;
    t_pad        r_pad, n_pad;
    logic [6:0]  r_cnt, n_cnt;
    logic [5:0]  r_pos;
    logic [63:0] r_bits;
    logic [4:0]  r_cvalid;
    logic        r_ov;

    // datapath
    logic [23:0] r_acc;
    logic [31:0] r_wv [NUM_CHAIN];
    logic [31:0] r_w [16];
    logic [31:0] r_dig;
    logic [2:0]  r_num;
    logic        r_fin;

    // memories
    logic [31:0] bmem [16];
    logic [31:0] cmem [NUM_CHAIN];
    logic [31:0] r_b_rdata;
    logic [31:0] r_c_rdata;
    logic        r_c_rvalid;
    logic [2:0]  r_c_raddr;

    // strobes
    logic        in_acc;
    logic        put_en;
    logic [7:0]  put_val;
    logic [7:0]  len_byte;
    logic        c_rd_en;
    logic [3:0]  b_rd_addr;
    logic        wv_load;
    logic        round_en;
    logic        c_wr_en;
    logic        out_load;
    logic        finish;
    logic [2:0]  cnt_m1;
    logic [31:0] c_eff;
    logic [31:0] w_t;
    logic [31:0] t_sum;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cnt_m1   = r_cnt[2:0] - 3'd1;
    assign c_eff    = r_c_rvalid ? r_c_rdata : H_INIT[r_c_raddr];
    assign len_byte = r_bits[{~r_pos[2:0], 3'b000} +: 8];

    always_comb begin
        n_state   = r_state;
        n_pad     = r_pad;
        n_cnt     = r_cnt;
        put_en    = 1'b0;
        put_val   = i_data_byte;
        c_rd_en   = 1'b0;
        b_rd_addr = 4'd0;
        wv_load   = 1'b0;
        round_en  = 1'b0;
        c_wr_en   = 1'b0;
        out_load  = 1'b0;
        finish    = 1'b0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_byte_present) begin
                        put_en = 1'b1;
                        if (r_pos == LAST_POS) begin
                            n_state = S_LOAD;
                            n_cnt   = 7'd0;
                            n_pad   = i_end_of_message ? PAD_MARK : PAD_NONE;
                        end else if (i_end_of_message) begin
                            n_state = S_PAD;
                            n_pad   = PAD_MARK;
                        end
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                        n_pad   = PAD_MARK;
                    end
                end
            end
            S_LOAD: begin
                c_rd_en = (r_cnt < 7'd5);
                wv_load = (r_cnt != 7'd0);
                if (r_cnt == 7'd5) begin
                    n_state = S_ROUND;
                    n_cnt   = 7'd0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_ROUND: begin
                round_en  = 1'b1;
                b_rd_addr = r_cnt[3:0] + 4'd1;
                if (r_cnt == 7'(NUM_ROUNDS - 1)) begin
                    n_state = S_ADD;
                    n_cnt   = 7'd0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_ADD: begin
                c_rd_en = (r_cnt < 7'd5);
                c_wr_en = (r_cnt != 7'd0);
                if (r_cnt == 7'd5) begin
                    n_cnt = 7'd0;
                    case (r_pad)
                        PAD_NONE: n_state = S_IDLE;
                        PAD_DONE: n_state = S_OUT_RD;
                        default:  n_state = S_PAD;
                    endcase
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_PAD: begin
                put_en = 1'b1;
                case (r_pad)
                    PAD_MARK: begin
                        put_val = PAD_MARK_BYTE;
                        n_pad   = PAD_ZERO;
                    end
                    PAD_ZERO: begin
                        if (r_pos == LEN_POS) begin
                            put_val = len_byte;
                            n_pad   = PAD_LEN;
                        end else begin
                            put_val = 8'd0;
                        end
                    end
                    default: begin
                        put_val = len_byte;
                        if (r_pos == LAST_POS) begin
                            n_pad = PAD_DONE;
                        end
                    end
                endcase
                if (r_pos == LAST_POS) begin
                    n_state = S_LOAD;
                    n_cnt   = 7'd0;
                end
            end
            S_OUT_RD: begin
                if (!r_ov || i_out_ready) begin
                    c_rd_en = 1'b1;
                    n_state = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                out_load = 1'b1;
                if (r_cnt == 7'd4) begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                    n_pad   = PAD_NONE;
                    n_cnt   = 7'd0;
                end else begin
                    n_state = S_OUT_RD;
                    n_cnt   = r_cnt + 7'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pad   <= PAD_NONE;
            r_cnt   <= 7'd0;
        end else begin
            r_state <= n_state;
            r_pad   <= n_pad;
            r_cnt   <= n_cnt;
        end
    end

    // byte position, bit count, chain entry valid bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 6'd0;
            r_bits   <= 64'd0;
            r_cvalid <= 5'd0;
            r_ov     <= 1'b0;
        end else begin
            if (put_en) begin
                r_pos <= r_pos + 6'd1;
            end
            if (finish) begin
                r_bits <= 64'd0;
            end else if (in_acc && i_byte_present) begin
                r_bits <= r_bits + 64'd8;
            end
            if (finish) begin
                r_cvalid <= 5'd0;
            end else if (c_wr_en) begin
                r_cvalid[cnt_m1] <= 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // block word memory
    always_ff @(posedge i_clk) begin
        if (put_en) begin
            if (r_pos[1:0] == 2'd3) begin
                bmem[r_pos[5:2]] <= {r_acc, put_val};
            end else begin
                r_acc <= {r_acc[15:0], put_val};
            end
        end
        r_b_rdata <= bmem[b_rd_addr];
    end

    // chain value memory
    always_ff @(posedge i_clk) begin
        if (c_wr_en) begin
            cmem[cnt_m1] <= c_eff + r_wv[cnt_m1];
        end
        if (c_rd_en) begin
            r_c_rdata  <= cmem[r_cnt[2:0]];
            r_c_rvalid <= r_cvalid[r_cnt[2:0]];
            r_c_raddr  <= r_cnt[2:0];
        end
    end

    // rounds and message schedule
    assign w_t = (r_cnt < 7'd16) ? r_b_rdata
               : {r_w[13][30:0] ^ r_w[8][30:0] ^ r_w[2][30:0] ^ r_w[0][30:0],
                  r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};
    assign t_sum = {r_wv[0][26:0], r_wv[0][31:27]}
                 + round_f(r_cnt, r_wv[1], r_wv[2], r_wv[3])
                 + r_wv[4] + round_k(r_cnt) + w_t;

    always_ff @(posedge i_clk) begin
        if (wv_load) begin
            r_wv[cnt_m1] <= c_eff;
        end else if (round_en) begin
            r_wv[0] <= t_sum;
            r_wv[1] <= r_wv[0];
            r_wv[2] <= {r_wv[1][1:0], r_wv[1][31:2]};
            r_wv[3] <= r_wv[2];
            r_wv[4] <= r_wv[3];
        end
        if (round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_t;
        end
    end

    // digest output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_dig <= c_eff;
            r_num <= r_cnt[2:0];
            r_fin <= (r_cnt == 7'd4);
        end
    end

    assign o_out_valid   = r_ov;
    assign o_digest_word = r_dig;
    assign o_word_number = r_num;
    assign o_final_word  = r_fin;

    a_final_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_fin == (r_num == 3'd4)))
        else $error("final flag does not match word number");

    a_idle_no_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_pad == PAD_NONE))
        else $error("word accepted while padding pending");

    a_len_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD && r_pad == PAD_LEN) |-> (r_pos[5:3] == 3'd7))
        else $error("length bytes outside block tail");

    a_add_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && r_cnt == 7'd0) |-> ($past(r_state) == S_ROUND))
        else $error("chain update without rounds");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_cnt < 7'(NUM_ROUNDS)))
        else $error("round counter out of range");

endmodule

`default_nettype wire
